// ===== sv/mstt_pkg.sv =====
package mstt_pkg;

   localparam int SLOTS   = 16;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RES_CAP = 16;
   localparam int NCNT_W  = $clog2(RES_CAP + 1);

   typedef enum logic [1:0] {
      OP_REG   = 2'd0,
      OP_UNREG = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_REG   = 3'd0,
      KIND_UNREG = 3'd1,
      KIND_FIRE  = 3'd2,
      KIND_NONE  = 3'd3,
      KIND_FULL  = 3'd4
   } kind_type;

   typedef struct packed {
      logic        periodic;
      logic [19:0] interval;
      logic [31:0] deadline;
      logic [31:0] tag;
   } slot_entry_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [31:0] tag;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_op_type;

   // low 4 bits of a slot index, zero extended when the index is narrower
   function automatic logic [3:0] slot4(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

endpackage

// ===== sv/mstt_if.sv =====
interface mstt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [19:0] interval;
   logic        periodic;
   logic [3:0]  slot_id;
   logic [31:0] user_tag;

   modport source (output valid, opcode, interval, periodic, slot_id, user_tag,
                   input ready);
   modport sink   (input valid, opcode, interval, periodic, slot_id, user_tag,
                   output ready);
endinterface

interface mstt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  result_slot;
   logic [31:0] result_tag;
   logic        last;

   modport source (output valid, kind, result_slot, result_tag, last,
                   input ready);
   modport sink   (input valid, kind, result_slot, result_tag, last,
                   output ready);
endinterface

// ===== sv/multi_slot_timer_table.sv =====
// channel   dir  fields                                          done when
// req_chan  in   opcode interval periodic slot_id user_tag      valid & ready
// rsp_chan  out  kind result_slot result_tag last               valid & ready
//
// One request at a time; ready only in the idle state.
// Register: scans for a free slot, one slot's valid bit checked per cycle.
// Unregister: clears the slot's valid bit. Tick: advances time, then reads each
// slot and evaluates it with the one shared 32-bit adder, reloading periodic fires.
// Synchronous reset empties the table and zeroes time; no clearing pass.
// A held response stalls the sequencer only when it must push another.
module multi_slot_timer_table (
   input  logic       clock,
   input  logic       reset,
   mstt_req_if.sink   req_chan,
   mstt_rsp_if.source rsp_chan
);

   typedef enum logic [7:0] {
      ST_IDLE        = 8'b0000_0001,
      ST_REG_SCAN    = 8'b0000_0010,
      ST_UNREG       = 8'b0000_0100,
      ST_TICK_INC    = 8'b0000_1000,
      ST_TICK_READ   = 8'b0001_0000,
      ST_TICK_EVAL   = 8'b0010_0000,
      ST_TICK_RELOAD = 8'b0100_0000,
      ST_TICK_DONE   = 8'b1000_0000
   } state_type;

   localparam int SW = mstt_pkg::SLOT_W;
   localparam int NW = mstt_pkg::NCNT_W;

   state_type                 state_ff, state_in;
   logic [SW-1:0]             idx_ff, idx_in;
   logic [NW-1:0]             n_ff, n_in;
   logic [31:0]               time_ff, time_in;
   logic [mstt_pkg::SLOTS-1:0] valid_ff, valid_in;
   mstt_pkg::result_type      pend_ff, pend_in;
   logic                      pend_valid_ff, pend_valid_in;
   mstt_pkg::result_type      out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;
   logic [19:0]               ivl_ff, ivl_in;
   logic                      per_ff, per_in;
   logic [3:0]                sid_ff, sid_in;
   logic [31:0]               tag_ff, tag_in;

   mstt_pkg::alu_op_type      alu_op;
   logic [31:0]               alu_sum;
   logic                      mem_wr_en, mem_rd_en;
   mstt_pkg::slot_entry_type  mem_wr_data, mem_rd_data;

   logic                      out_free;
   logic                      last_idx;
   logic                      fire;
   logic [SW+3:0]             sid_wide;
   logic [SW-1:0]             sid_idx;

   mstt_alu u_alu (
      .op  (alu_op),
      .sum (alu_sum)
   );

   mstt_slot_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (idx_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (mem_rd_data)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign last_idx = (idx_ff == SW'(mstt_pkg::SLOTS - 1));
   assign fire     = valid_ff[idx_ff] && alu_sum[31];
   assign sid_wide = {{SW{1'b0}}, sid_ff};
   assign sid_idx  = sid_wide[SW-1:0];

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_ff.kind;
   assign rsp_chan.result_slot = out_ff.slot;
   assign rsp_chan.result_tag  = out_ff.tag;
   assign rsp_chan.last        = out_ff.last;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      time_in       = time_ff;
      valid_in      = valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      ivl_in        = ivl_ff;
      per_in        = per_ff;
      sid_in        = sid_ff;
      tag_in        = tag_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_data   = mem_rd_data;
      alu_op        = '{a: 32'd0, b: 32'd0, sub: 1'b0};

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               ivl_in = req_chan.interval;
               per_in = req_chan.periodic;
               sid_in = req_chan.slot_id;
               tag_in = req_chan.user_tag;
               idx_in = '0;
               unique case (mstt_pkg::opcode_type'(req_chan.opcode))
                  mstt_pkg::OP_REG:   state_in = ST_REG_SCAN;
                  mstt_pkg::OP_UNREG: state_in = ST_UNREG;
                  mstt_pkg::OP_TICK:  state_in = ST_TICK_INC;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_REG_SCAN: begin
            alu_op = '{a: time_ff, b: {12'b0, ivl_ff}, sub: 1'b0};
            if (!valid_ff[idx_ff]) begin
               if (out_free) begin
                  mem_wr_en        = 1'b1;
                  mem_wr_data      = '{periodic: per_ff, interval: ivl_ff,
                                       deadline: alu_sum, tag: tag_ff};
                  valid_in[idx_ff] = 1'b1;
                  out_in           = '{kind: mstt_pkg::KIND_REG,
                                       slot: mstt_pkg::slot4(idx_ff),
                                       tag: 32'd0, last: 1'b1};
                  out_valid_in     = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else if (last_idx) begin
               if (out_free) begin
                  out_in       = '{kind: mstt_pkg::KIND_FULL, slot: 4'd0,
                                   tag: 32'd0, last: 1'b1};
                  out_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         ST_UNREG: begin
            if (out_free) begin
               if (32'(sid_ff) < 32'(mstt_pkg::SLOTS)) begin
                  valid_in[sid_idx] = 1'b0;
               end
               out_in       = '{kind: mstt_pkg::KIND_UNREG, slot: sid_ff,
                                tag: 32'd0, last: 1'b1};
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TICK_INC: begin
            alu_op        = '{a: time_ff, b: 32'd1, sub: 1'b0};
            time_in       = alu_sum;
            idx_in        = '0;
            n_in          = '0;
            pend_valid_in = 1'b0;
            state_in      = ST_TICK_READ;
         end
         ST_TICK_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_TICK_EVAL;
         end
         ST_TICK_EVAL: begin
            // deadline - now, negative means overdue
            alu_op = '{a: mem_rd_data.deadline, b: time_ff, sub: 1'b1};
            if (fire) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_valid_in = 1'b1;
                  end
                  pend_in       = '{kind: mstt_pkg::KIND_FIRE,
                                    slot: mstt_pkg::slot4(idx_ff),
                                    tag: mem_rd_data.tag, last: 1'b0};
                  pend_valid_in = 1'b1;
                  n_in          = n_ff + NW'(1);
                  if (mem_rd_data.periodic) begin
                     state_in = ST_TICK_RELOAD;
                  end else begin
                     valid_in[idx_ff] = 1'b0;
                     if (last_idx || (n_ff + NW'(1)) == NW'(mstt_pkg::RES_CAP)) begin
                        state_in = ST_TICK_DONE;
                     end else begin
                        idx_in   = idx_ff + SW'(1);
                        state_in = ST_TICK_READ;
                     end
                  end
               end
            end else if (last_idx) begin
               state_in = ST_TICK_DONE;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ST_TICK_READ;
            end
         end
         ST_TICK_RELOAD: begin
            alu_op      = '{a: time_ff, b: {12'b0, mem_rd_data.interval}, sub: 1'b0};
            mem_wr_en   = 1'b1;
            mem_wr_data = '{periodic: mem_rd_data.periodic,
                            interval: mem_rd_data.interval,
                            deadline: alu_sum, tag: mem_rd_data.tag};
            if (last_idx || n_ff == NW'(mstt_pkg::RES_CAP)) begin
               state_in = ST_TICK_DONE;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ST_TICK_READ;
            end
         end
         ST_TICK_DONE: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  out_in      = pend_ff;
                  out_in.last = 1'b1;
               end else begin
                  out_in = '{kind: mstt_pkg::KIND_NONE, slot: 4'd0,
                             tag: 32'd0, last: 1'b1};
               end
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         n_ff          <= '0;
         time_ff       <= 32'd0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         time_ff       <= time_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      ivl_ff  <= ivl_in;
      per_ff  <= per_in;
      sid_ff  <= sid_in;
      tag_ff  <= tag_in;
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !pend_valid_ff)
      else $error("pending fire left over in idle");

   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(mstt_pkg::RES_CAP))
      else $error("fire count beyond cap");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0 && !out_valid_ff))
      else $error("table or response not cleared by reset");

endmodule

// ===== sv/mstt_alu.sv =====
module mstt_alu (
   input  mstt_pkg::alu_op_type op,
   output logic [31:0]          sum
);

   assign sum = op.a + (op.sub ? ~op.b : op.b) + {31'b0, op.sub};

endmodule

// ===== sv/mstt_slot_mem.sv =====
module mstt_slot_mem (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [mstt_pkg::SLOT_W-1:0]    wr_addr,
   input  mstt_pkg::slot_entry_type       wr_data,
   input  logic                           rd_en,
   input  logic [mstt_pkg::SLOT_W-1:0]    rd_addr,
   output mstt_pkg::slot_entry_type       rd_data
);

   mstt_pkg::slot_entry_type mem [mstt_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
